>>> hdl/q9sfe_pkg.sv
// Shared types, node tables and result limits for the nine-node shape function evaluator.
package q9sfe_pkg;

    localparam int NUM_NODES = 9;
    localparam int NODE_W    = 4;
    localparam int VAL_W     = 17;
    localparam int COORD_W   = 16;

    typedef logic [NODE_W-1:0] node_t;

    // 1-D quadratic factor selector: end at -1, middle, end at +1
    typedef enum logic [1:0] {
        FSEL_END_LO,
        FSEL_MID,
        FSEL_END_HI
    } fsel_t;

    localparam node_t LAST_NODE = 4'd8;

    // corners, then midsides, then centre
    localparam fsel_t NODE_XSEL [NUM_NODES] = '{
        FSEL_END_LO, FSEL_END_HI, FSEL_END_HI, FSEL_END_LO,
        FSEL_MID, FSEL_END_HI, FSEL_MID, FSEL_END_LO, FSEL_MID
    };
    localparam fsel_t NODE_YSEL [NUM_NODES] = '{
        FSEL_END_LO, FSEL_END_LO, FSEL_END_HI, FSEL_END_HI,
        FSEL_END_LO, FSEL_MID, FSEL_END_HI, FSEL_MID, FSEL_MID
    };

    localparam logic signed [VAL_W-1:0] VAL_MAX = 17'h0FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 17'h10000;

    // per-stage advance strobes for the product lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } lane_en_t;

endpackage

>>> hdl/q9sfe_factor.sv
// Coordinate clamp and 1-D quadratic factor / derivative generation, four register stages.
module q9sfe_factor #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [q9sfe_pkg::COORD_W-1:0]          xi_in,
    input  logic [q9sfe_pkg::COORD_W-1:0]          eta_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0][2*FRAC_BITS+1:0]            fx_mag,
    output logic [2:0]                             fx_neg,
    output logic [2:0][2*FRAC_BITS+1:0]            fy_mag,
    output logic [2:0]                             fy_neg,
    output logic [2:0][2*FRAC_BITS+1:0]            dx_mag,
    output logic [2:0]                             dx_neg,
    output logic [2:0][2*FRAC_BITS+1:0]            dy_mag,
    output logic [2:0]                             dy_neg
);
    import q9sfe_pkg::*;

    localparam int CW  = FRAC_BITS + 2;
    localparam int IW  = (CW > COORD_W) ? CW : COORD_W;
    localparam int SQW = 2 * CW;
    localparam int FW  = 2 * FRAC_BITS + 3;
    localparam int DW  = FRAC_BITS + 4;
    localparam int MW  = 2 * FRAC_BITS + 2;

    localparam logic signed [IW-1:0] ONE_I      = IW'(1) <<< FRAC_BITS;
    localparam logic signed [DW-1:0] ONE_D      = DW'(1) <<< FRAC_BITS;
    localparam logic signed [FW-1:0] TWO_ONE_SQ = FW'(1) <<< (2 * FRAC_BITS + 1);

    function automatic logic signed [CW-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
        logic signed [IW-1:0] v;
        v = IW'($signed(raw));
        if (v > ONE_I)
            return CW'(ONE_I);
        else if (v < -ONE_I)
            return CW'(-ONE_I);
        else
            return CW'(v);
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] a;
        a = (v < 0) ? -v : v;
        return MW'(a);
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [CW-1:0]  x1_reg, y1_reg;
    logic signed [CW-1:0]  x2_reg, y2_reg;
    logic signed [SQW-1:0] xx2_reg, yy2_reg;
    logic signed [FW-1:0]  fx3_reg [3];
    logic signed [FW-1:0]  fy3_reg [3];
    logic signed [DW-1:0]  dx3_reg [3];
    logic signed [DW-1:0]  dy3_reg [3];
    logic [2:0][MW-1:0]    fx4_reg, fy4_reg, dx4_reg, dy4_reg;
    logic [2:0]            fxn4_reg, fyn4_reg, dxn4_reg, dyn4_reg;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg <= clamp_coord(xi_in);
            y1_reg <= clamp_coord(eta_in);
        end
        if (en2)
        begin
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            xx2_reg <= SQW'(x1_reg) * SQW'(x1_reg);
            yy2_reg <= SQW'(y1_reg) * SQW'(y1_reg);
        end
        if (en3)
        begin
            // factors carry a scale of 2*one^2, derivatives 2*one
            fx3_reg[0] <= FW'(xx2_reg) - (FW'(x2_reg) <<< FRAC_BITS);
            fx3_reg[1] <= TWO_ONE_SQ - (FW'(xx2_reg) <<< 1);
            fx3_reg[2] <= FW'(xx2_reg) + (FW'(x2_reg) <<< FRAC_BITS);
            fy3_reg[0] <= FW'(yy2_reg) - (FW'(y2_reg) <<< FRAC_BITS);
            fy3_reg[1] <= TWO_ONE_SQ - (FW'(yy2_reg) <<< 1);
            fy3_reg[2] <= FW'(yy2_reg) + (FW'(y2_reg) <<< FRAC_BITS);
            dx3_reg[0] <= (DW'(x2_reg) <<< 1) - ONE_D;
            dx3_reg[1] <= -(DW'(x2_reg) <<< 2);
            dx3_reg[2] <= (DW'(x2_reg) <<< 1) + ONE_D;
            dy3_reg[0] <= (DW'(y2_reg) <<< 1) - ONE_D;
            dy3_reg[1] <= -(DW'(y2_reg) <<< 2);
            dy3_reg[2] <= (DW'(y2_reg) <<< 1) + ONE_D;
        end
        if (en4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fx4_reg[i]  <= mag_of(fx3_reg[i]);
                fxn4_reg[i] <= fx3_reg[i][FW-1];
                fy4_reg[i]  <= mag_of(fy3_reg[i]);
                fyn4_reg[i] <= fy3_reg[i][FW-1];
                dx4_reg[i]  <= mag_of(FW'(dx3_reg[i]));
                dxn4_reg[i] <= dx3_reg[i][DW-1];
                dy4_reg[i]  <= mag_of(FW'(dy3_reg[i]));
                dyn4_reg[i] <= dy3_reg[i][DW-1];
            end
        end
    end

    assign out_valid = v4_reg;
    assign fx_mag    = fx4_reg;
    assign fx_neg    = fxn4_reg;
    assign fy_mag    = fy4_reg;
    assign fy_neg    = fyn4_reg;
    assign dx_mag    = dx4_reg;
    assign dx_neg    = dxn4_reg;
    assign dy_mag    = dy4_reg;
    assign dy_neg    = dyn4_reg;

endmodule

>>> hdl/q9sfe_lane.sv
// Signed-magnitude product lane: split multiply, partial sum, round half up, 17-bit saturation.
module q9sfe_lane #(
    parameter int FRAC_BITS = 14,
    parameter int RND_SHIFT = 44
) (
    input  logic                                 clk,
    input  q9sfe_pkg::lane_en_t                  en,
    input  logic [2*FRAC_BITS+1:0]               a_mag,
    input  logic                                 a_neg,
    input  logic [2*FRAC_BITS+1:0]               b_mag,
    input  logic                                 b_neg,
    output logic signed [q9sfe_pkg::VAL_W-1:0]   result
);
    import q9sfe_pkg::*;

    localparam int MW = 2 * FRAC_BITS + 2;
    localparam int HW = MW / 2;
    localparam int PW = 2 * MW;
    localparam int SW = PW + 1;
    localparam int QW = SW - RND_SHIFT;
    localparam int EW = (QW > VAL_W + 1) ? QW : VAL_W + 1;

    localparam logic signed [SW-1:0] HALF  = SW'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [EW-1:0] MAX_E = EW'(VAL_MAX);
    localparam logic signed [EW-1:0] MIN_E = EW'(VAL_MIN);

    logic [2*HW-1:0]      pll_reg, plh_reg, phl_reg, phh_reg;
    logic                 neg1_reg, neg2_reg;
    logic [PW-1:0]        sum2_reg;
    logic signed [QW-1:0] q3_reg;

    logic signed [SW-1:0] sum_s, sgn_s, rnd_s;
    logic signed [EW-1:0] q_e;

    always_comb
    begin
        sum_s = $signed({1'b0, sum2_reg});
        sgn_s = neg2_reg ? -sum_s : sum_s;
        rnd_s = sgn_s + HALF;
    end

    always_ff @(posedge clk)
    begin
        if (en.en1)
        begin
            pll_reg  <= MW'(a_mag[HW-1:0])  * MW'(b_mag[HW-1:0]);
            plh_reg  <= MW'(a_mag[HW-1:0])  * MW'(b_mag[MW-1:HW]);
            phl_reg  <= MW'(a_mag[MW-1:HW]) * MW'(b_mag[HW-1:0]);
            phh_reg  <= MW'(a_mag[MW-1:HW]) * MW'(b_mag[MW-1:HW]);
            neg1_reg <= a_neg ^ b_neg;
        end
        if (en.en2)
        begin
            sum2_reg <= PW'(pll_reg) + ((PW'(plh_reg) + PW'(phl_reg)) << HW)
                        + (PW'(phh_reg) << (2 * HW));
            neg2_reg <= neg1_reg;
        end
        if (en.en3)
            q3_reg <= QW'(rnd_s >>> RND_SHIFT);
    end

    always_comb
    begin
        q_e = EW'(q3_reg);
        if (q_e > MAX_E)
            result = VAL_MAX;
        else if (q_e < MIN_E)
            result = VAL_MIN;
        else
            result = VAL_W'(q_e);
    end

endmodule

>>> hdl/q9_shape_function_evaluator_top.sv
// Nine-node biquadratic quadrilateral shape functions and local gradients, streaming top level.
//
//  port group  | dir | payload (lowest bit first)
//  ------------+-----+--------------------------------------------------------------
//  s_t*        | in  | tdata: xi_coord[15:0], eta_coord[31:16]
//  m_t*        | out | tdata: node_number, shape_value, slope_xi, slope_eta, zero pad
//              |     | tlast: last_node
//
//  One input transaction yields nine output transactions, one per cycle while m_tready
//  is high, issued by the node sequencer feeding the single result channel; it takes the
//  next factor set as its last node issues, while the factor stages accept new inputs.
//  Path to the first result: 4 factor stages, sequencer, 3 product stages, output register.
//  No state is kept between items; reset only clears valid bits and the node count.
//  Back-pressure stalls each stage only when it is full, so bubbles close up.
module q9_shape_function_evaluator_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // xi_coord[15:0], eta_coord[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // node_number[3:0], shape_value[20:4],
                                    // slope_xi[37:21], slope_eta[54:38], pad[55]
    output logic        m_tlast     // last_node
);
    import q9sfe_pkg::*;

    localparam int MW        = 2 * FRAC_BITS + 2;
    localparam int SHIFT_VAL = 3 * FRAC_BITS + 2;
    localparam int SHIFT_DER = 2 * FRAC_BITS + 2;

    // factor generator outputs
    logic               fac_valid, fac_ready;
    logic [2:0][MW-1:0] fac_fx_mag, fac_fy_mag, fac_dx_mag, fac_dy_mag;
    logic [2:0]         fac_fx_neg, fac_fy_neg, fac_dx_neg, fac_dy_neg;

    // node sequencer: holds one item's factor set while its nine nodes issue
    logic               seq_v_reg, seq_v_next;
    node_t              cnt_reg, cnt_next;
    logic [2:0][MW-1:0] sfx_reg, sfy_reg, sdx_reg, sdy_reg;
    logic [2:0]         sfxn_reg, sfyn_reg, sdxn_reg, sdyn_reg;
    logic               seq_take, seq_last;
    fsel_t              xsel, ysel;

    // product pipeline control
    logic     v1_reg, v2_reg, v3_reg, out_v_reg;
    node_t    n1_reg, n2_reg, n3_reg, out_node_reg;
    logic     en1, en2, en3, en_out;
    lane_en_t lane_en;

    logic signed [VAL_W-1:0] val_res, sxi_res, seta_res;
    logic signed [VAL_W-1:0] out_val_reg, out_sxi_reg, out_seta_reg;

    q9sfe_factor #(
        .FRAC_BITS (FRAC_BITS)
    ) u_factor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .xi_in     (s_tdata[15:0]),
        .eta_in    (s_tdata[31:16]),
        .out_valid (fac_valid),
        .out_ready (fac_ready),
        .fx_mag    (fac_fx_mag),
        .fx_neg    (fac_fx_neg),
        .fy_mag    (fac_fy_mag),
        .fy_neg    (fac_fy_neg),
        .dx_mag    (fac_dx_mag),
        .dx_neg    (fac_dx_neg),
        .dy_mag    (fac_dy_mag),
        .dy_neg    (fac_dy_neg)
    );

    assign en_out  = !out_v_reg || m_tready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign lane_en = '{en1: en1, en2: en2, en3: en3};

    assign seq_last  = (cnt_reg == LAST_NODE);
    assign fac_ready = !seq_v_reg || (seq_last && en1);
    assign seq_take  = fac_valid && fac_ready;

    always_comb
    begin
        seq_v_next = seq_v_reg;
        cnt_next   = cnt_reg;
        if (seq_take)
        begin
            seq_v_next = 1'b1;
            cnt_next   = '0;
        end
        else if (seq_v_reg && en1)
        begin
            if (seq_last)
                seq_v_next = 1'b0;
            else
                cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_v_reg <= 1'b0;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            seq_v_reg <= seq_v_next;
            cnt_reg   <= cnt_next;
            if (en1)    v1_reg    <= seq_v_reg;
            if (en2)    v2_reg    <= v1_reg;
            if (en3)    v3_reg    <= v2_reg;
            if (en_out) out_v_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            sfx_reg  <= fac_fx_mag;
            sfy_reg  <= fac_fy_mag;
            sdx_reg  <= fac_dx_mag;
            sdy_reg  <= fac_dy_mag;
            sfxn_reg <= fac_fx_neg;
            sfyn_reg <= fac_fy_neg;
            sdxn_reg <= fac_dx_neg;
            sdyn_reg <= fac_dy_neg;
        end
        if (en1) n1_reg <= cnt_reg;
        if (en2) n2_reg <= n1_reg;
        if (en3) n3_reg <= n2_reg;
        if (en_out)
        begin
            out_node_reg <= n3_reg;
            out_val_reg  <= val_res;
            out_sxi_reg  <= sxi_res;
            out_seta_reg <= seta_res;
        end
    end

    assign xsel = NODE_XSEL[cnt_reg];
    assign ysel = NODE_YSEL[cnt_reg];

    // N = fx * fy, dN/dxi = dx * fy, dN/deta = fx * dy
    q9sfe_lane #(
        .FRAC_BITS (FRAC_BITS),
        .RND_SHIFT (SHIFT_VAL)
    ) u_lane_val (
        .clk    (clk),
        .en     (lane_en),
        .a_mag  (sfx_reg[xsel]),
        .a_neg  (sfxn_reg[xsel]),
        .b_mag  (sfy_reg[ysel]),
        .b_neg  (sfyn_reg[ysel]),
        .result (val_res)
    );

    q9sfe_lane #(
        .FRAC_BITS (FRAC_BITS),
        .RND_SHIFT (SHIFT_DER)
    ) u_lane_xi (
        .clk    (clk),
        .en     (lane_en),
        .a_mag  (sdx_reg[xsel]),
        .a_neg  (sdxn_reg[xsel]),
        .b_mag  (sfy_reg[ysel]),
        .b_neg  (sfyn_reg[ysel]),
        .result (sxi_res)
    );

    q9sfe_lane #(
        .FRAC_BITS (FRAC_BITS),
        .RND_SHIFT (SHIFT_DER)
    ) u_lane_eta (
        .clk    (clk),
        .en     (lane_en),
        .a_mag  (sfx_reg[xsel]),
        .a_neg  (sfxn_reg[xsel]),
        .b_mag  (sdy_reg[ysel]),
        .b_neg  (sdyn_reg[ysel]),
        .result (seta_res)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, out_seta_reg, out_sxi_reg, out_val_reg, out_node_reg};
    assign m_tlast  = (out_node_reg == LAST_NODE);

    // node count never runs past the centre node
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_v_reg |-> (cnt_reg <= LAST_NODE))
        else $error("node count out of range");

    // an issued node that is not the last is followed by the next node
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_v_reg && en1 && !seq_last) |=> (seq_v_reg && cnt_reg == $past(cnt_reg) + 4'd1))
        else $error("node sequencer skipped or repeated a node");

    // the first two product stages, when both full, hold consecutive nodes
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> ((n1_reg == n2_reg + 4'd1) ||
                                (n2_reg == LAST_NODE && n1_reg == 4'd0)))
        else $error("product pipeline node order broken");

endmodule

>>> sim/q9_shape_function_evaluator_top_tb.sv
// Testbench for the nine-node shape function evaluator: checks every node result against a predictor.
module q9_shape_function_evaluator_top_tb;

    import q9sfe_pkg::*;

    localparam int FRAC       = 14;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 30;

    // one node result as it leaves the block
    typedef struct packed {
        node_t            node;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] d_xi;
        logic [VAL_W-1:0] d_eta;
        logic             last_node;
    } node_result_t;

    class shape_scoreboard;
        node_result_t node_results_q[$];
        int pairs_seen;
        int pairs_clamped;
        int results_seen;
        int mismatches;

        function longint clamp_coord(logic [COORD_W-1:0] raw);
            longint one;
            longint v;
            one = longint'(1) <<< FRAC;
            v = longint'($signed(raw));
            if (v > one)
                v = one;
            if (v < -one)
                v = -one;
            return v;
        endfunction

        // round(a * b / 2^k), ties up, clipped to the result width
        function logic [VAL_W-1:0] round_scaled(longint a, longint b, int k);
            longint p;
            p = (a * b + (longint'(1) <<< (k - 1))) >>> k;
            if (p > longint'(VAL_MAX))
                return VAL_MAX;
            if (p < longint'(VAL_MIN))
                return VAL_MIN;
            return p[VAL_W-1:0];
        endfunction

        function void note_coords(logic [COORD_W-1:0] xi_raw, logic [COORD_W-1:0] eta_raw);
            longint one;
            longint x;
            longint y;
            longint fx [3];
            longint fy [3];
            longint dx [3];
            longint dy [3];
            int a;
            int b;
            node_result_t r;
            one = longint'(1) <<< FRAC;
            x = clamp_coord(xi_raw);
            y = clamp_coord(eta_raw);
            if (x != longint'($signed(xi_raw)) || y != longint'($signed(eta_raw)))
                pairs_clamped++;
            pairs_seen++;
            // 1-D factors carry a scale of 2*one^2, their slopes 2*one
            fx[FSEL_END_LO] = x * x - x * one;
            fx[FSEL_MID]    = 2 * one * one - 2 * x * x;
            fx[FSEL_END_HI] = x * x + x * one;
            fy[FSEL_END_LO] = y * y - y * one;
            fy[FSEL_MID]    = 2 * one * one - 2 * y * y;
            fy[FSEL_END_HI] = y * y + y * one;
            dx[FSEL_END_LO] = 2 * x - one;
            dx[FSEL_MID]    = -4 * x;
            dx[FSEL_END_HI] = 2 * x + one;
            dy[FSEL_END_LO] = 2 * y - one;
            dy[FSEL_MID]    = -4 * y;
            dy[FSEL_END_HI] = 2 * y + one;
            for (int n = 0; n < NUM_NODES; n++)
            begin
                a = int'(NODE_XSEL[n]);
                b = int'(NODE_YSEL[n]);
                r.node      = node_t'(n);
                r.value     = round_scaled(fx[a], fy[b], 3 * FRAC + 2);
                r.d_xi      = round_scaled(dx[a], fy[b], 2 * FRAC + 2);
                r.d_eta     = round_scaled(fx[a], dy[b], 2 * FRAC + 2);
                r.last_node = (node_t'(n) == LAST_NODE);
                node_results_q.push_back(r);
            end
        endfunction

        function void report(string what, node_result_t want, node_result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: expected node %0d N=%0d dxi=%0d deta=%0d last=%0b",
                         what, want.node, $signed(want.value), $signed(want.d_xi),
                         $signed(want.d_eta), want.last_node);
                $display("    got node %0d N=%0d dxi=%0d deta=%0d last=%0b",
                         got.node, $signed(got.value), $signed(got.d_xi),
                         $signed(got.d_eta), got.last_node);
            end
        endfunction

        function void check_result(logic [55:0] data, logic tlast_bit);
            node_result_t got;
            node_result_t want;
            got.node      = data[3:0];
            got.value     = data[20:4];
            got.d_xi      = data[37:21];
            got.d_eta     = data[54:38];
            got.last_node = tlast_bit;
            results_seen++;
            if (node_results_q.size() == 0)
            begin
                want = '0;
                report("unexpected result", want, got);
                return;
            end
            want = node_results_q.pop_front();
            if (got.node !== want.node || got.value !== want.value || got.d_xi !== want.d_xi
                || got.d_eta !== want.d_eta || got.last_node !== want.last_node)
                report("mismatch", want, got);
        endfunction

        function int pending();
            return node_results_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    shape_scoreboard sb = new();
    bit steady = 1'b0;
    bit first_item = 1'b1;
    int stall_left = 0;

    q9_shape_function_evaluator_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    function logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return COORD_W'($urandom_range(0, 32768) - 16384);
            6:       return COORD_W'($urandom_range(0, 128) - 64);
            7, 8:    return COORD_W'($urandom_range(0, 65535));
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return COORD_W'(-16384);
                    1:       return COORD_W'(0);
                    default: return COORD_W'(16384);
                endcase
            end
        endcase
    endfunction

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_length() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // valid stays high across back-to-back items; it drops during a gap and while results drain
    task automatic send_coords(logic [COORD_W-1:0] xi, logic [COORD_W-1:0] eta);
        int gap;
        gap = (steady || first_item) ? 0 : (($urandom_range(0, 99) < 50) ? 0 : gap_length());
        first_item = 1'b0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {eta, xi};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_coords(xi, eta);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        first_item = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [COORD_W-1:0] directed_xi [20];
        logic [COORD_W-1:0] directed_eta [20];
        directed_xi  = '{16'hC000, 16'h4000, 16'h4000, 16'hC000, 16'h0000, 16'h4000,
                         16'h0000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000, 16'h4001,
                         16'h2000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'hAAAA, 16'h5555,
                         16'hBFFF, 16'h3039};
        directed_eta = '{16'hC000, 16'hC000, 16'h4000, 16'h4000, 16'hC000, 16'h0000,
                         16'h4000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'hBFFF,
                         16'hE000, 16'hFFFF, 16'h0001, 16'hC001, 16'h5555, 16'hAAAA,
                         16'h2000, 16'hF752};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // node positions, out-of-range coordinates, bit patterns
        steady = 1'b1;
        for (int i = 0; i < 10; i++)
            send_coords(directed_xi[i], directed_eta[i]);
        steady = 1'b0;
        for (int i = 10; i < 20; i++)
            send_coords(directed_xi[i], directed_eta[i]);
        drain_results();

        for (int i = 0; i < 160; i++)
        begin
            steady = ((i / 20) % 4 == 1);
            if (i == 80)
                drain_results();
            send_coords(rand_coord(), rand_coord());
        end
        drain_results();
        steady = 1'b0;
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Covered %0d coordinate pairs (%0d needing saturation)",
                 sb.pairs_seen, sb.pairs_clamped);
        $display("%0d node results checked under gaps and stalls, with full-rate stretches",
                 sb.results_seen);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
